// ===== sv/hmq_pkg.sv =====
// Shared constants and types for the heightmap height query block.
// No dependencies; imported by heightmap_height_query, hmq_locate and hmq_blend.
`timescale 1ns / 1ps

package hmq_pkg;

    localparam int COORD_W   = 32;  // Q16.16 coordinates and Q16.16 scale
    localparam int FRAC_W    = 16;  // in-cell fraction, Q0.16
    localparam int HEIGHT_W  = 16;  // Q8.8 heights on the ports
    localparam int CFG_IDX_W = 2;
    localparam int NUM_BANKS = 4;   // one bank per (row parity, column parity)

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL = 2'd2;

    localparam logic MODE_QUERY = 1'b1;

    localparam logic [FRAC_W:0]    FRAC_ONE       = 17'h1_0000;
    localparam logic [COORD_W-1:0] INV_CELL_RESET = 32'h0001_0000;

    // Cell info that travels beside the bank read data into the blend stages
    typedef struct packed {
        logic              in_range;
        logic              col_odd;
        logic              row_odd;
        logic [FRAC_W-1:0] frac_x;
        logic [FRAC_W-1:0] frac_z;
    } blend_ctl_t;

endpackage

// ===== sv/heightmap_height_query.sv =====
// Heightmap height query. Load beats (mode 0) write one vertex height; query beats
// (mode 1) return the interpolated terrain height under a world X,Z point, one result
// per query and none per load. The block takes one beat per clock while the output is
// not stalled, and a query passes through the five-stage pipeline (offset, 32x32 scale
// multiply, table read, weight multiply, sum) into the output register; a stall on the
// output holds every stage. The vertex table is split into four banks by row and column
// parity, each with one read and one write port, so the four corners of a cell come out
// in a single read. Loads write their bank in stage two, in order with the queries
// around them. The table is not cleared: a query that touches a vertex never loaded
// returns an undefined height.
`timescale 1ns / 1ps

module heightmap_height_query
    import hmq_pkg::*;
#(
    parameter int GRID_VERTICES = 256,
    parameter int HEIGHT_BITS   = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic        [COORD_W-1:0]   cfg_data,
    // input beats
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic signed [COORD_W-1:0]   world_x,
    input  logic signed [COORD_W-1:0]   world_z,
    input  logic        [7:0]           vertex_col,
    input  logic        [7:0]           vertex_row,
    input  logic signed [HEIGHT_W-1:0]  height_in,
    // result beats
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [HEIGHT_W-1:0]  height_out,
    output logic                        in_range
);

    localparam int HALF    = (GRID_VERTICES + 1) / 2;
    localparam int HALF_W  = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int BANK_AW = 2 * HALF_W;
    localparam int STORE_W = (HEIGHT_BITS < HEIGHT_W) ? HEIGHT_BITS : HEIGHT_W;

    // ---------------- configuration ----------------
    logic signed [COORD_W-1:0] origin_x_reg, origin_z_reg;
    logic        [COORD_W-1:0] inv_cell_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_z_reg <= '0;
            inv_cell_reg <= INV_CELL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_data;
                REG_ORIGIN_Z: origin_z_reg <= cfg_data;
                REG_INV_CELL: inv_cell_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic q1_reg, q2_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            q1_reg        <= 1'b0;
            q2_reg        <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            q1_reg        <= (mode == MODE_QUERY);
            v2_reg        <= v1_reg;
            q2_reg        <= q1_reg;
            v3_reg        <= v2_reg && q2_reg;   // loads end in stage two
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // ---------------- load payload, stages one and two ----------------
    logic               ld_ok1_reg, ld_ok2_reg;
    logic [7:0]         col1_reg, row1_reg, col2_reg, row2_reg;
    logic [STORE_W-1:0] h1_reg, h2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ld_ok1_reg <= (32'(vertex_col) < GRID_VERTICES)
                       && (32'(vertex_row) < GRID_VERTICES);
            col1_reg   <= vertex_col;
            row1_reg   <= vertex_row;
            h1_reg     <= height_in[STORE_W-1:0];
            ld_ok2_reg <= ld_ok1_reg;
            col2_reg   <= col1_reg;
            row2_reg   <= row1_reg;
            h2_reg     <= h1_reg;
        end
    end

    // ---------------- coordinate stages ----------------
    logic [HALF_W:0]   cell_x, cell_z;
    logic [FRAC_W-1:0] frac_x, frac_z;
    logic              grid_x, grid_z;

    hmq_locate #(
        .GRID_VERTICES (GRID_VERTICES),
        .HALF_W        (HALF_W)
    ) u_locate_x (
        .clk      (clk),
        .adv      (adv),
        .world    (world_x),
        .origin   (origin_x_reg),
        .inv_cell (inv_cell_reg),
        .cell_idx (cell_x),
        .frac     (frac_x),
        .in_grid  (grid_x)
    );

    hmq_locate #(
        .GRID_VERTICES (GRID_VERTICES),
        .HALF_W        (HALF_W)
    ) u_locate_z (
        .clk      (clk),
        .adv      (adv),
        .world    (world_z),
        .origin   (origin_z_reg),
        .inv_cell (inv_cell_reg),
        .cell_idx (cell_z),
        .frac     (frac_z),
        .in_grid  (grid_z)
    );

    // ---------------- banked vertex table ----------------
    logic                 wr_en;
    logic [1:0]           wr_bank;
    logic [BANK_AW-1:0]   wr_addr;
    logic [NUM_BANKS-1:0] bank_we;
    logic [HALF_W-1:0]    col_half [2];
    logic [HALF_W-1:0]    row_half [2];
    logic [STORE_W-1:0]   bank_rdata [NUM_BANKS];

    assign wr_en   = adv && v2_reg && !q2_reg && ld_ok2_reg;
    assign wr_bank = {row2_reg[0], col2_reg[0]};
    assign wr_addr = {HALF_W'(row2_reg >> 1), HALF_W'(col2_reg >> 1)};

    // Bank of parity p holds the corner whose index has that parity: the cell
    // index itself or the one after it.
    for (genvar p = 0; p < 2; p++)
    begin : g_half
        logic [HALF_W:0] col_sum, row_sum;
        assign col_sum     = cell_x + (HALF_W+1)'(cell_x[0] ^ 1'(p));
        assign row_sum     = cell_z + (HALF_W+1)'(cell_z[0] ^ 1'(p));
        assign col_half[p] = col_sum[HALF_W:1];
        assign row_half[p] = row_sum[HALF_W:1];
    end

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        assign bank_we[b] = wr_en && (wr_bank == 2'(b));

        hmq_ram #(
            .DATA_W (STORE_W),
            .ADDR_W (BANK_AW)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (wr_addr),
            .wdata (h2_reg),
            .re    (adv),
            .raddr ({row_half[b / 2], col_half[b % 2]}),
            .rdata (bank_rdata[b])
        );
    end

    // cell info registered alongside the bank read
    blend_ctl_t ctl3_reg, ctl3_next;

    always_comb
    begin
        ctl3_next.in_range = grid_x && grid_z;
        ctl3_next.col_odd  = cell_x[0];
        ctl3_next.row_odd  = cell_z[0];
        ctl3_next.frac_x   = frac_x;
        ctl3_next.frac_z   = frac_z;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl3_reg <= ctl3_next;
        end
    end

    // ---------------- blend and output register ----------------
    hmq_blend #(
        .STORE_W (STORE_W)
    ) u_blend (
        .clk        (clk),
        .adv        (adv),
        .ctl        (ctl3_reg),
        .bank_rdata (bank_rdata),
        .height     (height_out),
        .in_range   (in_range)
    );

    assign out_valid = out_valid_reg;

    // ---------------- checks ----------------
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> height_out == '0)
        else $error("out-of-range result carries a nonzero height");

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v4_reg))
        else $error("result appeared without a query in stage four");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg, q1_reg, q2_reg}))
        else $error("pipeline moved during an output stall");

    a_no_write_on_query: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && q2_reg |-> bank_we == '0)
        else $error("table written while a query sits in stage two");

endmodule

// ===== sv/hmq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module hmq_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/hmq_locate.sv =====
// One axis of the query: origin subtract, then scale by the reciprocal cell size.
// Two register stages; depends on hmq_pkg.
`timescale 1ns / 1ps

module hmq_locate
    import hmq_pkg::*;
#(
    parameter int GRID_VERTICES = 256,
    parameter int HALF_W        = 7
) (
    input  logic                      clk,
    input  logic                      adv,
    input  logic signed [COORD_W-1:0] world,
    input  logic signed [COORD_W-1:0] origin,
    input  logic        [COORD_W-1:0] inv_cell,
    output logic        [HALF_W:0]    cell_idx,
    output logic        [FRAC_W-1:0]  frac,
    output logic                      in_grid
);

    localparam logic [COORD_W-1:0] CELL_LIMIT = COORD_W'(GRID_VERTICES - 1);

    logic signed [COORD_W:0]     t_reg, t_next;
    logic        [2*COORD_W-1:0] prod_reg, prod_next;
    logic                        neg_reg, neg_next;

    // A non-negative offset is below 2^32, so the low word is all the multiplier
    // needs. A negative offset is dropped unless the scale is zero, and then
    // the product is zero anyway.
    always_comb
    begin
        t_next    = (COORD_W+1)'(world) - (COORD_W+1)'(origin);
        prod_next = (2*COORD_W)'(t_reg[COORD_W-1:0]) * (2*COORD_W)'(inv_cell);
        neg_next  = t_reg[COORD_W] && (inv_cell != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg    <= t_next;
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
        end
    end

    assign cell_idx = prod_reg[COORD_W +: HALF_W+1];
    assign frac     = prod_reg[COORD_W-1 -: FRAC_W];
    assign in_grid  = !neg_reg && (prod_reg[2*COORD_W-1:COORD_W] < CELL_LIMIT);

endmodule

// ===== sv/hmq_blend.sv =====
// Triangle blend: corner pick, weights and three products, then sum and Q8.8 floor.
// Two register stages; depends on hmq_pkg.
`timescale 1ns / 1ps

module hmq_blend
    import hmq_pkg::*;
#(
    parameter int STORE_W = 16
) (
    input  logic                       clk,
    input  logic                       adv,
    input  blend_ctl_t                 ctl,
    input  logic        [STORE_W-1:0]  bank_rdata [NUM_BANKS],
    output logic signed [HEIGHT_W-1:0] height,
    output logic                       in_range
);

    localparam int PROD_W = STORE_W + FRAC_W + 2;
    localparam int ACC_W  = 2*HEIGHT_W + 4;

    logic [FRAC_W:0]           fsum;
    logic                      lower;
    logic [FRAC_W:0]           w_near, w_col, w_row;
    logic signed [STORE_W-1:0] h00, h10, h01, h11, h_near;
    logic signed [PROD_W-1:0]  pa_next, pb_next, pc_next;
    logic signed [PROD_W-1:0]  pa_reg, pb_reg, pc_reg;
    logic                      rng4_reg;
    logic signed [ACC_W-1:0]   acc;
    logic signed [HEIGHT_W-1:0] height_reg, height_next;
    logic                      rng5_reg;

    // Banks are indexed {row parity, column parity}; map them back to corners.
    always_comb
    begin
        h00 = bank_rdata[{ctl.row_odd, ctl.col_odd}];
        h10 = bank_rdata[{ctl.row_odd, !ctl.col_odd}];
        h01 = bank_rdata[{!ctl.row_odd, ctl.col_odd}];
        h11 = bank_rdata[{!ctl.row_odd, !ctl.col_odd}];

        fsum  = {1'b0, ctl.frac_x} + {1'b0, ctl.frac_z};
        lower = (fsum <= FRAC_ONE);

        // h10 and h01 appear in both triangles; the third corner is h00 or h11
        if (lower)
        begin
            h_near = h00;
            w_near = FRAC_ONE - fsum;
            w_col  = {1'b0, ctl.frac_x};
            w_row  = {1'b0, ctl.frac_z};
        end
        else
        begin
            h_near = h11;
            w_near = fsum - FRAC_ONE;
            w_col  = FRAC_ONE - {1'b0, ctl.frac_z};
            w_row  = FRAC_ONE - {1'b0, ctl.frac_x};
        end

        pa_next = h_near * $signed({1'b0, w_near});
        pb_next = h10 * $signed({1'b0, w_col});
        pc_next = h01 * $signed({1'b0, w_row});
    end

    always_comb
    begin
        acc = ACC_W'(pa_reg) + ACC_W'(pb_reg) + ACC_W'(pc_reg);
        // arithmetic shift by 16 is the floor back to Q8.8
        height_next = rng4_reg ? acc[FRAC_W +: HEIGHT_W] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            pc_reg     <= pc_next;
            rng4_reg   <= ctl.in_range;
            height_reg <= height_next;
            rng5_reg   <= rng4_reg;
        end
    end

    assign height   = height_reg;
    assign in_range = rng5_reg;

endmodule
